// ===== hw/rtl/tks_pkg.sv =====
// tks_pkg: types, codes and character tables for the token scanner
// no dependencies; used by token_scanner, token_checker and tb_token_scanner
package tks_pkg;

  localparam int unsigned NAME_MAX = 64;

  localparam logic [5:0] KIND_INT    = 6'd0;
  localparam logic [5:0] KIND_FLOAT  = 6'd1;
  localparam logic [5:0] KIND_IDENT  = 6'd2;
  localparam logic [5:0] KIND_STRING = 6'd3;
  localparam logic [5:0] KIND_EOF    = 6'd4;
  localparam logic [5:0] KIND_ERROR  = 6'd5;
  localparam logic [5:0] KIND_PUNCT0 = 6'd6;
  localparam logic [5:0] KIND_OTHER  = 6'd34;

  localparam logic [30:0] INT_TOP  = 31'h7FFF_FFFF;
  localparam logic [23:0] LINE_TOP = 24'hFF_FFFF;
  localparam logic [15:0] COL_TOP  = 16'hFFFF;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int unsigned NUM_PUNCT = 28;

  // + - * / ( ) [ ] { } < > = ' , . ; : % # ! ~ @ $ & \ ? |
  localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
    8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
    8'h3C, 8'h3E, 8'h3D, 8'h27, 8'h2C, 8'h2E, 8'h3B, 8'h3A, 8'h25, 8'h23,
    8'h21, 8'h7E, 8'h40, 8'h24, 8'h26, 8'h5C, 8'h3F, 8'h7C
  };

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'd0,
    MODE_COMMENT  = 4'd1,
    MODE_NUM      = 4'd2,
    MODE_EXP_MARK = 4'd3,
    MODE_EXP_SIGN = 4'd4,
    MODE_EXP_DIG  = 4'd5,
    MODE_IDENT    = 4'd6,
    MODE_STRING   = 4'd7
  } mode_t;

  localparam logic [1:0] REG_COMMENTS_ON   = 2'd0;
  localparam logic [1:0] REG_COMMENT_BEGIN = 2'd1;
  localparam logic [1:0] REG_COMMENT_END   = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_mark;
  } in_item_t;

  typedef struct packed {
    logic        result_type;
    logic [7:0]  text_char;
    logic [5:0]  token_kind;
    logic [6:0]  token_length;
    logic [30:0] integer_value;
    logic [23:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } out_item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    logic [5:0] k;
    k = KIND_OTHER;
    for (int i = 0; i < NUM_PUNCT; i++) begin
      if (c == PUNCT_CHARS[i]) k = KIND_PUNCT0 + 6'(i);
    end
    return k;
  endfunction

endpackage

// ===== hw/rtl/token_scanner.sv =====
// token_scanner: streaming lexical scanner, one character item per cycle while the result queue has room
// depends on tks_pkg for item types, token kinds and character tables

// Takes one character (or an end-of-input mark) per cycle and produces zero, one
// or two result items for it: echoed text characters and completed tokens with
// kind, length, integer value and line/column. Each accepted item is scanned in
// the cycle it is accepted and its results go into a four-entry result queue,
// readable from the next cycle, so in_ready stays high as long as the queue has
// room for two results. With out_ready held high the block takes one input item
// per clock while the results keep pace with the single output: the queue absorbs
// one two-result item, and each further two-result item that arrives before the
// queue has drained stalls the input until the output has taken a result, so a run
// of them goes no faster than the output drains. Configuration writes are taken at
// any time and should only be made while the block is idle.
module token_scanner (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tks_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tks_pkg::out_item_t out_data,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  // configuration
  logic       comments_on;
  logic [7:0] comment_begin;
  logic [7:0] comment_end;

  // scanner state
  tks_pkg::mode_t mode, mode_next;
  logic [6:0]  text_count, text_count_next;
  logic [30:0] int_accum, int_accum_next;
  logic [23:0] line_count, line_count_next;
  logic [15:0] col_count, col_count_next;
  logic        seen_fraction, seen_fraction_next;
  logic        finished, finished_next;

  // result queue
  tks_pkg::out_item_t fifo [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;

  logic       accept;
  logic       pop;
  logic [7:0] c;
  logic       eof;

  assign accept = in_valid && in_ready;
  assign pop    = out_valid && out_ready;
  assign c      = in_data.char_in;
  assign eof    = in_data.end_mark;

  // idle scan of the current character
  tks_pkg::mode_t idle_mode;
  logic       idle_text;
  logic       idle_tok;
  logic [5:0] idle_kind;
  logic       idle_start;
  logic       idle_num;
  logic       idle_str;
  logic       idle_fin;

  always_comb begin
    idle_mode  = tks_pkg::MODE_IDLE;
    idle_text  = 1'b0;
    idle_tok   = 1'b0;
    idle_kind  = tks_pkg::KIND_EOF;
    idle_start = 1'b0;
    idle_num   = 1'b0;
    idle_str   = 1'b0;
    idle_fin   = 1'b0;
    priority if (eof) begin
      idle_tok = 1'b1;
      idle_fin = 1'b1;
    end else if (comments_on && (c == comment_begin)) begin
      idle_mode = tks_pkg::MODE_COMMENT;
    end else if (tks_pkg::is_digit(c)) begin
      idle_mode  = tks_pkg::MODE_NUM;
      idle_text  = 1'b1;
      idle_start = 1'b1;
      idle_num   = 1'b1;
    end else if (tks_pkg::is_alpha(c)) begin
      idle_mode  = tks_pkg::MODE_IDENT;
      idle_text  = 1'b1;
      idle_start = 1'b1;
    end else if ((c == tks_pkg::CH_SPACE) || (c == tks_pkg::CH_LF) ||
                 (c == tks_pkg::CH_CR) || (c == tks_pkg::CH_TAB)) begin
      idle_mode = tks_pkg::MODE_IDLE;
    end else if (c == tks_pkg::CH_QUOTE) begin
      idle_mode = tks_pkg::MODE_STRING;
      idle_str  = 1'b1;
    end else begin
      idle_tok  = 1'b1;
      idle_kind = tks_pkg::single_kind(c);
    end
  end

  // saturating decimal accumulate
  logic [34:0] accum_prod;
  logic [30:0] accum_sat;

  always_comb begin
    accum_prod = ({4'd0, int_accum} << 3) + ({4'd0, int_accum} << 1) + 35'(c[3:0]);
    accum_sat  = (accum_prod > 35'(tks_pkg::INT_TOP)) ? tks_pkg::INT_TOP
                                                       : accum_prod[30:0];
  end

  logic dig;
  logic can_add;
  assign dig     = !eof && tks_pkg::is_digit(c);
  assign can_add = text_count < 7'(tks_pkg::NAME_MAX);

  logic           take;
  tks_pkg::mode_t take_mode;
  logic           take_digit;
  logic           take_dot;
  logic           fail;
  logic           emit;
  logic [5:0]     emit_kind;
  logic [6:0]     emit_len;
  logic [30:0]    emit_val;
  logic           go_idle;
  logic           b_valid;
  tks_pkg::out_item_t tok_a, res_b, r0, r1;
  logic [1:0]     n_res;

  always_comb begin
    mode_next          = mode;
    text_count_next    = text_count;
    int_accum_next     = int_accum;
    seen_fraction_next = seen_fraction;
    finished_next      = finished;
    line_count_next    = line_count;
    col_count_next     = col_count;
    take       = 1'b0;
    take_mode  = mode;
    take_digit = 1'b0;
    take_dot   = 1'b0;
    fail       = 1'b0;
    emit       = 1'b0;
    emit_kind  = tks_pkg::KIND_EOF;
    emit_len   = 7'd0;
    emit_val   = 31'd0;
    go_idle    = 1'b0;
    b_valid    = 1'b0;
    res_b      = '0;
    tok_a      = '0;
    r0         = '0;
    r1         = '0;
    n_res      = 2'd0;

    if (!finished && !eof) begin
      if (c == tks_pkg::CH_LF) begin
        if (line_count < tks_pkg::LINE_TOP) line_count_next = line_count + 24'd1;
        col_count_next = 16'd0;
      end else if (col_count < tks_pkg::COL_TOP) begin
        col_count_next = col_count + 16'd1;
      end
    end

    if (!finished) begin
      unique case (mode)
        tks_pkg::MODE_COMMENT: begin
          if (eof) fail = 1'b1;
          else if (c == comment_end) mode_next = tks_pkg::MODE_IDLE;
        end
        tks_pkg::MODE_NUM: begin
          priority if (dig) begin
            take       = 1'b1;
            take_digit = !seen_fraction;
          end else if (!eof && (c == tks_pkg::CH_DOT) && !seen_fraction) begin
            take     = 1'b1;
            take_dot = 1'b1;
          end else if (!eof && ((c == tks_pkg::CH_LO_E) || (c == tks_pkg::CH_UP_E))) begin
            take      = 1'b1;
            take_mode = tks_pkg::MODE_EXP_MARK;
          end else begin
            emit      = 1'b1;
            emit_kind = seen_fraction ? tks_pkg::KIND_FLOAT : tks_pkg::KIND_INT;
            emit_len  = text_count;
            emit_val  = seen_fraction ? 31'd0 : int_accum;
            go_idle   = 1'b1;
          end
        end
        tks_pkg::MODE_EXP_MARK: begin
          priority if (!eof && ((c == tks_pkg::CH_PLUS) || (c == tks_pkg::CH_MINUS))) begin
            take      = 1'b1;
            take_mode = tks_pkg::MODE_EXP_SIGN;
          end else if (dig) begin
            take      = 1'b1;
            take_mode = tks_pkg::MODE_EXP_DIG;
          end else begin
            fail = 1'b1;
          end
        end
        tks_pkg::MODE_EXP_SIGN: begin
          if (dig) begin
            take      = 1'b1;
            take_mode = tks_pkg::MODE_EXP_DIG;
          end else begin
            fail = 1'b1;
          end
        end
        tks_pkg::MODE_EXP_DIG: begin
          if (dig) begin
            take = 1'b1;
          end else begin
            emit      = 1'b1;
            emit_kind = tks_pkg::KIND_FLOAT;
            emit_len  = text_count;
            go_idle   = 1'b1;
          end
        end
        tks_pkg::MODE_IDENT: begin
          if (!eof && (tks_pkg::is_alpha(c) || tks_pkg::is_digit(c) ||
                       (c == tks_pkg::CH_UNDER))) begin
            take = 1'b1;
          end else begin
            emit      = 1'b1;
            emit_kind = tks_pkg::KIND_IDENT;
            emit_len  = text_count;
            go_idle   = 1'b1;
          end
        end
        tks_pkg::MODE_STRING: begin
          priority if (eof) begin
            fail = 1'b1;
          end else if (c == tks_pkg::CH_QUOTE) begin
            emit      = 1'b1;
            emit_kind = tks_pkg::KIND_STRING;
            emit_len  = text_count;
            mode_next = tks_pkg::MODE_IDLE;
          end else begin
            take = 1'b1;
          end
        end
        default: go_idle = 1'b1;
      endcase

      // text full: error, then rescan from idle
      if (take) begin
        if (can_add) begin
          b_valid           = 1'b1;
          res_b.result_type = 1'b0;
          res_b.text_char   = c;
          text_count_next   = text_count + 7'd1;
          mode_next         = take_mode;
          if (take_digit) int_accum_next = accum_sat;
          if (take_dot) seen_fraction_next = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end

      if (fail) begin
        emit      = 1'b1;
        emit_kind = tks_pkg::KIND_ERROR;
        emit_len  = 7'd0;
        emit_val  = 31'd0;
        go_idle   = 1'b1;
      end

      if (go_idle) begin
        mode_next = idle_mode;
        if (idle_start) text_count_next = 7'd1;
        if (idle_str) text_count_next = 7'd0;
        if (idle_num) begin
          seen_fraction_next = 1'b0;
          int_accum_next     = 31'(c[3:0]);
        end
        if (idle_fin) finished_next = 1'b1;
        if (idle_text) begin
          b_valid           = 1'b1;
          res_b.result_type = 1'b0;
          res_b.text_char   = c;
        end else if (idle_tok) begin
          b_valid           = 1'b1;
          res_b.result_type = 1'b1;
          res_b.token_kind  = idle_kind;
        end
      end

      tok_a.result_type   = 1'b1;
      tok_a.token_kind    = emit_kind;
      tok_a.token_length  = emit_len;
      tok_a.integer_value = emit_val;

      if (emit) begin
        r0    = tok_a;
        r1    = res_b;
        n_res = b_valid ? 2'd2 : 2'd1;
      end else begin
        r0    = res_b;
        n_res = b_valid ? 2'd1 : 2'd0;
      end
    end else begin
      // after end of input every item gives one eof token
      r0.result_type = 1'b1;
      r0.token_kind  = tks_pkg::KIND_EOF;
      n_res          = 2'd1;
    end

    r0.line_number   = line_count_next;
    r0.column_number = col_count_next;
    r1.line_number   = line_count_next;
    r1.column_number = col_count_next;
    r0.last_of_run   = (n_res == 2'd1);
    r1.last_of_run   = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comments_on   <= 1'b0;
      comment_begin <= 8'd123;
      comment_end   <= 8'd125;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        tks_pkg::REG_COMMENTS_ON:   comments_on   <= cfg_data[0];
        tks_pkg::REG_COMMENT_BEGIN: comment_begin <= cfg_data;
        tks_pkg::REG_COMMENT_END:   comment_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= tks_pkg::MODE_IDLE;
      text_count    <= 7'd0;
      int_accum     <= 31'd0;
      line_count    <= 24'd0;
      col_count     <= 16'd0;
      seen_fraction <= 1'b0;
      finished      <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      text_count    <= text_count_next;
      int_accum     <= int_accum_next;
      line_count    <= line_count_next;
      col_count     <= col_count_next;
      seen_fraction <= seen_fraction_next;
      finished      <= finished_next;
    end
  end

  logic [2:0] push_cnt;
  assign push_cnt = accept ? {1'b0, n_res} : 3'd0;

  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) fifo[wr_ptr] <= r0;
    if (accept && (n_res == 2'd2)) fifo[wr_ptr + 2'd1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + push_cnt - {2'd0, pop};
    end
  end

  assign in_ready  = fill <= 3'd2;
  assign out_valid = fill != 3'd0;
  assign out_data  = fifo[rd_ptr];

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 3'd4)
    else $error("result queue overfilled");

  a_finished_sticks: assert property (@(posedge clk) disable iff (rst)
    finished |=> finished)
    else $error("end of input state lost");

  a_text_bound: assert property (@(posedge clk) disable iff (rst)
    text_count <= 7'(tks_pkg::NAME_MAX))
    else $error("token text longer than limit");

endmodule

// ===== tb/token_checker.sv =====
// token_checker: watches the token scanner's channels, predicts its result items
// and compares them field by field; depends on tks_pkg for item types and codes
module token_checker
  import tks_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_wen,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // end of input travels through the predicting model as a ninth code bit
  localparam logic [8:0] EOF_CODE = 9'h100;
  localparam int unsigned PRINT_LIMIT = 40;
  // punctuation in kind order, first character in the top byte
  localparam logic [8*28-1:0] PUNCT_SET = "+-*/()[]{}<>=',.;:%#!~@$&\\?|";

  logic        comm_on;
  logic [7:0]  comm_begin;
  logic [7:0]  comm_end;
  mode_t       mode;
  logic [6:0]  text_cnt;
  logic [30:0] int_acc;
  logic [23:0] line_cnt;
  logic [15:0] col_cnt;
  logic        in_fraction;
  logic        done;

  out_item_t   step_buf [2];
  int          step_n;
  out_item_t   expected_results [$];

  function automatic bit digit_ch(logic [8:0] c);
    return (c >= 9'h030) && (c <= 9'h039);
  endfunction

  function automatic bit letter_ch(logic [8:0] c);
    return ((c >= 9'h061) && (c <= 9'h07A)) || ((c >= 9'h041) && (c <= 9'h05A));
  endfunction

  function automatic logic [5:0] punct_kind(logic [8:0] c);
    logic [5:0] k;
    k = KIND_OTHER;
    for (int i = 0; i < 28; i++) begin
      if (c == {1'b0, PUNCT_SET[8*(27-i) +: 8]}) k = KIND_PUNCT0 + 6'(i);
    end
    return k;
  endfunction

  function automatic void push_result(logic rtype, logic [7:0] ch, logic [5:0] kind,
                                      logic [6:0] len, logic [30:0] val);
    out_item_t r;
    if (step_n >= 2) return;
    r.result_type   = rtype;
    r.text_char     = ch;
    r.token_kind    = kind;
    r.token_length  = len;
    r.integer_value = val;
    r.line_number   = line_cnt;
    r.column_number = col_cnt;
    r.last_of_run   = 1'b0;
    step_buf[step_n] = r;
    step_n++;
  endfunction

  function automatic void emit_token(logic [5:0] kind, logic [6:0] len, logic [30:0] val);
    push_result(1'b1, 8'd0, kind, len, val);
  endfunction

  function automatic bit add_text(logic [8:0] c);
    if (text_cnt >= NAME_MAX) return 1'b0;
    text_cnt++;
    push_result(1'b0, c[7:0], 6'd0, 7'd0, 31'd0);
    return 1'b1;
  endfunction

  function automatic void scan_idle(logic [8:0] c);
    mode = MODE_IDLE;
    if (c == EOF_CODE) begin
      emit_token(KIND_EOF, 7'd0, 31'd0);
      done = 1'b1;
    end else if (comm_on && c == {1'b0, comm_begin}) begin
      mode = MODE_COMMENT;
    end else if (digit_ch(c)) begin
      text_cnt    = 7'd0;
      in_fraction = 1'b0;
      int_acc     = 31'(c[3:0]);
      void'(add_text(c));
      mode = MODE_NUM;
    end else if (letter_ch(c)) begin
      text_cnt = 7'd0;
      void'(add_text(c));
      mode = MODE_IDENT;
    end else if (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB) begin
      // blanks between tokens are dropped
    end else if (c == CH_QUOTE) begin
      text_cnt = 7'd0;
      mode = MODE_STRING;
    end else begin
      emit_token(punct_kind(c), 7'd0, 31'd0);
    end
  endfunction

  function automatic void fail_rescan(logic [8:0] c);
    emit_token(KIND_ERROR, 7'd0, 31'd0);
    scan_idle(c);
  endfunction

  function automatic void take_or_fail(logic [8:0] c, mode_t next_mode);
    if (add_text(c)) mode = next_mode;
    else fail_rescan(c);
  endfunction

  function automatic void scan_char(logic [8:0] c);
    logic [35:0] grown;
    case (mode)
      MODE_COMMENT: begin
        if (c == EOF_CODE) fail_rescan(c);
        else if (c == {1'b0, comm_end}) mode = MODE_IDLE;
      end
      MODE_NUM: begin
        if (digit_ch(c)) begin
          if (add_text(c)) begin
            if (!in_fraction) begin
              grown   = {5'd0, int_acc} * 36'd10 + 36'(c[3:0]);
              int_acc = (grown > 36'(INT_TOP)) ? INT_TOP : grown[30:0];
            end
          end else begin
            fail_rescan(c);
          end
        end else if (c == CH_DOT && !in_fraction) begin
          if (add_text(c)) in_fraction = 1'b1;
          else fail_rescan(c);
        end else if (c == CH_LO_E || c == CH_UP_E) begin
          take_or_fail(c, MODE_EXP_MARK);
        end else begin
          if (in_fraction) emit_token(KIND_FLOAT, text_cnt, 31'd0);
          else emit_token(KIND_INT, text_cnt, int_acc);
          scan_idle(c);
        end
      end
      MODE_EXP_MARK: begin
        if (c == CH_PLUS || c == CH_MINUS) take_or_fail(c, MODE_EXP_SIGN);
        else if (digit_ch(c)) take_or_fail(c, MODE_EXP_DIG);
        else fail_rescan(c);
      end
      MODE_EXP_SIGN: begin
        if (digit_ch(c)) take_or_fail(c, MODE_EXP_DIG);
        else fail_rescan(c);
      end
      MODE_EXP_DIG: begin
        if (digit_ch(c)) begin
          take_or_fail(c, MODE_EXP_DIG);
        end else begin
          emit_token(KIND_FLOAT, text_cnt, 31'd0);
          scan_idle(c);
        end
      end
      MODE_IDENT: begin
        if (letter_ch(c) || digit_ch(c) || c == CH_UNDER) begin
          take_or_fail(c, MODE_IDENT);
        end else begin
          emit_token(KIND_IDENT, text_cnt, 31'd0);
          scan_idle(c);
        end
      end
      MODE_STRING: begin
        if (c == EOF_CODE) begin
          fail_rescan(c);
        end else if (c == CH_QUOTE) begin
          emit_token(KIND_STRING, text_cnt, 31'd0);
          mode = MODE_IDLE;
        end else begin
          take_or_fail(c, MODE_STRING);
        end
      end
      default: scan_idle(c);
    endcase
  endfunction

  function automatic void predict_item(in_item_t it);
    logic [8:0] c;
    step_n = 0;
    if (done) begin
      emit_token(KIND_EOF, 7'd0, 31'd0);
    end else begin
      if (it.end_mark) begin
        c = EOF_CODE;
      end else begin
        c = {1'b0, it.char_in};
        if (c == CH_LF) begin
          if (line_cnt < LINE_TOP) line_cnt++;
          col_cnt = 16'd0;
        end else if (col_cnt < COL_TOP) begin
          col_cnt++;
        end
      end
      scan_char(c);
    end
    if (step_n > 0) step_buf[step_n-1].last_of_run = 1'b1;
    for (int i = 0; i < step_n; i++) expected_results.push_back(step_buf[i]);
  endfunction

  function automatic void reset_scanner();
    comm_on     = 1'b0;
    comm_begin  = 8'd123;
    comm_end    = 8'd125;
    mode        = MODE_IDLE;
    text_cnt    = 7'd0;
    int_acc     = 31'd0;
    line_cnt    = 24'd0;
    col_cnt     = 16'd0;
    in_fraction = 1'b0;
    done        = 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count < PRINT_LIMIT) $display("mismatch: %s got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      reset_scanner();
      expected_results = {};
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with none expected, kind", 64'(out_data.token_kind), 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_type !== want.result_type)
            report_mismatch("result_type", 64'(out_data.result_type), 64'(want.result_type));
          if (out_data.text_char !== want.text_char)
            report_mismatch("text_char", 64'(out_data.text_char), 64'(want.text_char));
          if (out_data.token_kind !== want.token_kind)
            report_mismatch("token_kind", 64'(out_data.token_kind), 64'(want.token_kind));
          if (out_data.token_length !== want.token_length)
            report_mismatch("token_length", 64'(out_data.token_length),
                            64'(want.token_length));
          if (out_data.integer_value !== want.integer_value)
            report_mismatch("integer_value", 64'(out_data.integer_value),
                            64'(want.integer_value));
          if (out_data.line_number !== want.line_number)
            report_mismatch("line_number", 64'(out_data.line_number), 64'(want.line_number));
          if (out_data.column_number !== want.column_number)
            report_mismatch("column_number", 64'(out_data.column_number),
                            64'(want.column_number));
          if (out_data.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", 64'(out_data.last_of_run), 64'(want.last_of_run));
        end
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_COMMENTS_ON:   comm_on    = cfg_data[0];
          REG_COMMENT_BEGIN: comm_begin = cfg_data;
          REG_COMMENT_END:   comm_end   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_item(in_data);
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/tb_token_scanner.sv =====
// tb_token_scanner: clock, reset, character stimulus and verdict for token_scanner
// depends on tks_pkg, token_scanner and token_checker
module tb_token_scanner;
  timeunit 1ns;
  timeprecision 1ps;
  import tks_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int CFG_SETTLE   = 8;
  localparam int END_SETTLE   = 16;
  localparam int PHASE_ITEMS  = 205;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_wen;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         pending;

  int         send_idle_pct;
  int         stall_pct;
  logic       hold_request;
  int         sent_items;
  logic [7:0] cur_begin;
  logic [7:0] cur_end;

  token_scanner u_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_wen, .cfg_index, .cfg_data
  );

  token_checker u_check (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_wen, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver side: random stalls, plus one long hold-off counted here
  initial begin
    int  held;
    logic hold_done;
    held      = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        out_ready <= (int'($urandom_range(99)) >= stall_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic eoi);
    @(negedge clk);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{char_in: ch, end_mark: eoi};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_letter();
    int n;
    n = $urandom_range(51);
    return (n < 26) ? 8'h61 + 8'(n) : 8'h41 + 8'(n - 26);
  endfunction

  function automatic logic [7:0] printable_except(input logic [7:0] bad);
    logic [7:0] ch;
    do ch = 8'($urandom_range(32, 126)); while (ch == bad);
    return ch;
  endfunction

  // one well-formed token with random content, now and then broken or noise
  task automatic send_token();
    int pick;
    int n;
    int sep;
    logic [7:0] ch;
    pick = $urandom_range(99);
    n = ($urandom_range(29) == 0) ? 60 + $urandom_range(8) : 0;
    if (pick < 18) begin
      if (n == 0) n = $urandom_range(1, 12);
      repeat (n) send_item(rand_digit(), 1'b0);
    end else if (pick < 32) begin
      repeat ($urandom_range(1, 4)) send_item(rand_digit(), 1'b0);
      if ($urandom_range(1)) begin
        send_item(CH_DOT, 1'b0);
        repeat ($urandom_range(0, 4)) send_item(rand_digit(), 1'b0);
      end
      if ($urandom_range(2) == 0) begin
        send_item($urandom_range(1) ? CH_LO_E : CH_UP_E, 1'b0);
        if ($urandom_range(1)) send_item($urandom_range(1) ? CH_PLUS : CH_MINUS, 1'b0);
        // an exponent with no digit now and then
        if ($urandom_range(5) != 0) repeat ($urandom_range(1, 3)) send_item(rand_digit(), 1'b0);
      end
    end else if (pick < 50) begin
      if (n == 0) n = $urandom_range(1, 8);
      send_item(rand_letter(), 1'b0);
      repeat (n - 1) begin
        case ($urandom_range(2))
          0: ch = rand_digit();
          1: ch = CH_UNDER;
          default: ch = rand_letter();
        endcase
        send_item(ch, 1'b0);
      end
    end else if (pick < 62) begin
      if (n == 0) n = $urandom_range(0, 8);
      send_item(CH_QUOTE, 1'b0);
      repeat (n) send_item(printable_except(CH_QUOTE), 1'b0);
      send_item(CH_QUOTE, 1'b0);
    end else if (pick < 70) begin
      send_item(cur_begin, 1'b0);
      repeat ($urandom_range(0, 6)) send_item(printable_except(cur_end), 1'b0);
      send_item(cur_end, 1'b0);
    end else if (pick < 80) begin
      send_item(8'($urandom_range(33, 126)), 1'b0);
    end else if (pick < 90) begin
      case ($urandom_range(3))
        0: ch = CH_SPACE;
        1: ch = CH_TAB;
        2: ch = CH_CR;
        default: ch = CH_LF;
      endcase
      send_item(ch, 1'b0);
    end else begin
      send_item(8'($urandom_range(255)), 1'b0);
    end
    sep = $urandom_range(3);
    if (sep == 0) send_item(CH_SPACE, 1'b0);
    else if (sep == 1) send_item(CH_LF, 1'b0);
  endtask

  task automatic wait_drained(input int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_config(input logic on, input logic [7:0] b, input logic [7:0] e);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_COMMENTS_ON;
    cfg_data  <= {7'd0, on};
    @(negedge clk);
    cfg_index <= REG_COMMENT_BEGIN;
    cfg_data  <= b;
    @(negedge clk);
    cfg_index <= REG_COMMENT_END;
    cfg_data  <= e;
    @(negedge clk);
    cfg_wen <= 1'b0;
    cur_begin = b;
    cur_end   = e;
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input int n_items);
    int start;
    start = sent_items;
    send_idle_pct = idle_pct;
    stall_pct <= stall;
    while (sent_items - start < n_items) send_token();
    wait_drained(CFG_SETTLE);
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_wen       = 1'b0;
    cfg_index     = REG_COMMENTS_ON;
    cfg_data      = 8'd0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    sent_items    = 0;
    cur_begin     = 8'd123;
    cur_end       = 8'd125;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: comments off, so braces are punctuation
    send_text("0 9.25e-7 z_Z9\"\"1E+.{} ");
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b0);
    run_phase(0, 0, PHASE_ITEMS);

    write_config(1'b1, 8'd123, 8'd125);
    run_phase(76, 0, PHASE_ITEMS);
    write_config(1'b1, 8'h00, 8'hFF);
    run_phase(0, 76, PHASE_ITEMS);
    write_config(1'b1, 8'hFF, 8'h00);
    run_phase(37, 37, PHASE_ITEMS);

    // receiver holds off while items keep coming, so the result queue fills
    write_config(1'b0, 8'h23, CH_LF);
    hold_request <= 1'b1;
    run_phase(0, 0, PHASE_ITEMS);

    // same character opens and closes a comment
    write_config(1'b1, 8'h2F, 8'h2F);
    run_phase(20, 37, PHASE_ITEMS);

    // end of input lands in one of several contexts; afterwards only eof tokens
    case ($urandom_range(3))
      0: begin
        send_item(CH_QUOTE, 1'b0);
        send_text("ab");
      end
      1: begin
        send_item(cur_begin, 1'b0);
        send_text("x");
      end
      2: send_text("12");
      default: ;
    endcase
    send_item(8'($urandom_range(255)), 1'b1);
    repeat (6) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));

    stall_pct <= 0;
    wait_drained(END_SETTLE);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
